### hdl/npat_pkg.sv
// shared types and constants of the neighbour presence ageing table
`timescale 1ns / 1ps
package npat_pkg;

  // field widths fixed by the frame format
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PRES_W  = 8;
  localparam int unsigned CONN_W  = 2;
  localparam int unsigned ENTRY_W = PRES_W + CONN_W;

  // connectable hold loaded by an advert
  localparam logic [CONN_W-1:0] CONNECT_HOLD = 2'd2;

  // configuration register map
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_RELOAD  = 1'b0;
  localparam logic        REG_CLK_FLT = 1'b1;
  localparam logic [PRES_W-1:0] RELOAD_RST = 8'd4;

  // received function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEACON   = 2'd0,
    FUNC_ADVERT   = 2'd1,
    FUNC_DOWNLOAD = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REJECTED  = 3'd0,
    KIND_REFRESHED = 3'd1,
    KIND_ARRIVAL   = 3'd2,
    KIND_DEPARTURE = 3'd3,
    KIND_UPLOAD    = 3'd4,
    KIND_DONE      = 3'd5
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_EMIT,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

### hdl/neighbor_presence_aging_table_unit.sv
// neighbour presence ageing table: frame handling, interval sweep and config port
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  func, sender_id, frame_ok, remote_time,
//                                          remote_authoritative, remote_fault
//   out_     output     out_valid/out_ready kind, peer_id, clock_time,
//                                          clock_authoritative, last
//   cfg      apb write  psel/penable/pwrite presence_reload @0, local_clock_fault @4
//
// a beacon or advert: accept, then one table read-modify-write and the result.
// a tick: the entry updater walks the table memory one entry a cycle unless a
// departure stalls, the next entry read while the current one is written back.
// a full result register stalls the sequencer where it must emit; a new transaction
// is taken as soon as the sequencer is idle, even while a result waits.
// synchronous active-low reset clears one valid flop per entry, so no clearing pass.
`timescale 1ns / 1ps
module neighbor_presence_aging_table_unit
  import npat_pkg::*;
#(
  parameter int unsigned NUM_PEERS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_sender_id,
  input  logic                in_frame_ok,
  input  logic [TIME_W-1:0]   in_remote_time,
  input  logic                in_remote_authoritative,
  input  logic                in_remote_fault,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [ID_W-1:0]     out_peer_id,
  output logic [TIME_W-1:0]   out_clock_time,
  output logic                out_clock_authoritative,
  output logic                out_last,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PEERS - 1);

  state_t state_r, state_nxt;

  // configuration registers
  logic [PRES_W-1:0] reload_r;
  logic              clk_fault_r;

  // kept clock
  logic [TIME_W-1:0] kept_time_r;
  logic              kept_auth_r;

  // captured transaction
  func_t             func_r;
  logic [ID_W-1:0]   sender_r;
  logic [TIME_W-1:0] rtime_r;
  logic              rauth_r;
  logic              rfault_r;
  kind_t             kind_r, kind_nxt;

  // table memory and its valid flops
  logic [ENTRY_W-1:0]   mem [NUM_PEERS];
  logic [ENTRY_W-1:0]   rdata_r;
  logic [NUM_PEERS-1:0] vld_r;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 mem_we;
  logic [ENTRY_W-1:0]   wdata;

  // result register
  logic              out_valid_r;
  kind_t             out_kind_r, okind_nxt;
  logic [ID_W-1:0]   out_peer_r, opeer_nxt;
  logic [TIME_W-1:0] out_time_r;
  logic              out_auth_r;
  logic              out_last_r, olast_nxt;
  logic              out_load;
  logic              out_free;

  // entry updater signals
  logic              ent_vld;
  logic [PRES_W-1:0] pres_old, pres_dec;
  logic [CONN_W-1:0] conn_old, conn_dec, conn_frame;
  logic              depart;
  logic              arrived;
  logic              at_last;
  logic              step_go;
  logic              clk_upd;
  logic              in_acc;
  logic              in_reject;

  assign out_free  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign in_reject = !in_frame_ok || (in_sender_id >= ID_W'(NUM_PEERS));
  assign at_last   = (addr_r == LAST_IDX);

  // entry updater: one entry per use, shared by frames and the sweep
  always_comb begin
    ent_vld    = vld_r[addr_r];
    pres_old   = ent_vld ? rdata_r[PRES_W-1:0] : '0;
    conn_old   = ent_vld ? rdata_r[ENTRY_W-1:PRES_W] : '0;
    pres_dec   = (pres_old == '0) ? '0 : pres_old - PRES_W'(1);
    conn_dec   = (conn_old == '0) ? '0 : conn_old - CONN_W'(1);
    depart     = (pres_old == PRES_W'(1));
    arrived    = (pres_old == '0);
    conn_frame = (func_r == FUNC_ADVERT) ? CONNECT_HOLD : conn_old;
    step_go    = !depart || out_free;
  end

  // clock adoption rule for beacons
  always_comb begin
    clk_upd = (state_r == ST_FRAME) && out_free && (func_r == FUNC_BEACON) && !rfault_r
              && (!kept_auth_r || clk_fault_r)
              && (rauth_r || (rtime_r > kept_time_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_TICK) begin
            state_nxt = ST_SWEEP;
          end else if (in_reject || (in_func == FUNC_DOWNLOAD)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (step_go && at_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    wdata     = {conn_dec, pres_dec};
    out_load  = 1'b0;
    okind_nxt = kind_r;
    opeer_nxt = sender_r;
    olast_nxt = 1'b1;
    addr_nxt  = addr_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_TICK) begin
            addr_nxt = '0;
          end else if (in_reject) begin
            kind_nxt = KIND_REJECTED;
          end else begin
            kind_nxt = KIND_UPLOAD;
            addr_nxt = in_sender_id[IDX_W-1:0];
          end
        end
      end
      ST_FRAME: begin
        wdata     = {conn_frame, reload_r};
        okind_nxt = arrived ? KIND_ARRIVAL : KIND_REFRESHED;
        if (out_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
        end
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_SWEEP: begin
        okind_nxt = KIND_DEPARTURE;
        opeer_nxt = ID_W'(addr_r);
        olast_nxt = 1'b0;
        if (step_go) begin
          mem_we   = 1'b1;
          out_load = depart;
          if (!at_last) addr_nxt = addr_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        okind_nxt = KIND_DONE;
        opeer_nxt = '0;
        out_load  = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state, clock and valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kept_time_r <= '0;
      kept_auth_r <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      if (clk_upd) begin
        kept_time_r <= rtime_r;
        kept_auth_r <= rauth_r;
      end
      if (mem_we) vld_r[addr_r] <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // table memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= wdata;
    rdata_r <= mem[addr_nxt];
  end

  // transaction capture and result payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    if (in_acc) begin
      func_r   <= func_t'(in_func);
      sender_r <= in_sender_id;
      rtime_r  <= in_remote_time;
      rauth_r  <= in_remote_authoritative;
      rfault_r <= in_remote_fault;
    end
    if (out_load) begin
      out_kind_r <= okind_nxt;
      out_peer_r <= opeer_nxt;
      out_time_r <= clk_upd ? rtime_r : kept_time_r;
      out_auth_r <= clk_upd ? rauth_r : kept_auth_r;
      out_last_r <= olast_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r    <= RELOAD_RST;
      clk_fault_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_RELOAD:  reload_r    <= pwdata[PRES_W-1:0];
        REG_CLK_FLT: clk_fault_r <= pwdata[0];
        default:     reload_r    <= reload_r;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[2])
      REG_RELOAD:  prdata = {{(32 - PRES_W){1'b0}}, reload_r};
      REG_CLK_FLT: prdata = {31'b0, clk_fault_r};
      default:     prdata = '0;
    endcase
  end

  assign pready                  = 1'b1;
  assign out_valid               = out_valid_r;
  assign out_kind                = out_kind_r;
  assign out_peer_id             = out_peer_r;
  assign out_clock_time          = out_time_r;
  assign out_clock_authoritative = out_auth_r;
  assign out_last                = out_last_r;

endmodule

### hdl/npat_checker.sv
// port-level checks of the neighbour presence ageing table and their bind
`timescale 1ns / 1ps
module npat_checker
  import npat_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [ID_W-1:0]   out_peer_id,
  input logic              out_last
);

  // a stalled result holds its kind and peer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_peer_id))
    else $error("stalled result changed");

  // a transaction is processed before the next is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // the done record closes a tick and names no peer
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE) |-> out_last && (out_peer_id == '0))
    else $error("bad tick done record");

  // only departures are followed by more results of the same transaction
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_kind == KIND_DEPARTURE))
    else $error("non-final result that is not a departure");

endmodule

bind neighbor_presence_aging_table_unit npat_checker u_npat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_peer_id (out_peer_id),
  .out_last    (out_last)
);
